@@ rtl/core/asqv_pkg.sv @@
// ----------------------------------------------------------------------------
// asqv_pkg: shared constants and sine table for the arc segment quad block
// Holds the default fixed-point formats, the field widths and the
// quarter-wave sine table in Q1.16, whole degrees 0..90.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asqv_pkg;

    // default fixed-point formats
    localparam int ANGLE_FRAC_BITS = 4;
    localparam int TRIG_FRAC_BITS  = 15;

    // field widths
    localparam int COORD_W = 8;
    localparam int ANGLE_W = 14;
    localparam int TABLE_W = 17;

    // round(sin(deg) * 2^16) for whole degrees 0..90
    function automatic logic [TABLE_W-1:0] sine_q16(input logic [6:0] deg);
        logic [TABLE_W-1:0] val;
        case (deg)
            7'd0:  val = 17'd0;     7'd1:  val = 17'd1144;  7'd2:  val = 17'd2287;
            7'd3:  val = 17'd3430;  7'd4:  val = 17'd4572;  7'd5:  val = 17'd5712;
            7'd6:  val = 17'd6850;  7'd7:  val = 17'd7987;  7'd8:  val = 17'd9121;
            7'd9:  val = 17'd10252; 7'd10: val = 17'd11380; 7'd11: val = 17'd12505;
            7'd12: val = 17'd13626; 7'd13: val = 17'd14742; 7'd14: val = 17'd15855;
            7'd15: val = 17'd16962; 7'd16: val = 17'd18064; 7'd17: val = 17'd19161;
            7'd18: val = 17'd20252; 7'd19: val = 17'd21336; 7'd20: val = 17'd22415;
            7'd21: val = 17'd23486; 7'd22: val = 17'd24550; 7'd23: val = 17'd25607;
            7'd24: val = 17'd26656; 7'd25: val = 17'd27697; 7'd26: val = 17'd28729;
            7'd27: val = 17'd29753; 7'd28: val = 17'd30767; 7'd29: val = 17'd31772;
            7'd30: val = 17'd32768; 7'd31: val = 17'd33754; 7'd32: val = 17'd34729;
            7'd33: val = 17'd35693; 7'd34: val = 17'd36647; 7'd35: val = 17'd37590;
            7'd36: val = 17'd38521; 7'd37: val = 17'd39441; 7'd38: val = 17'd40348;
            7'd39: val = 17'd41243; 7'd40: val = 17'd42126; 7'd41: val = 17'd42995;
            7'd42: val = 17'd43852; 7'd43: val = 17'd44695; 7'd44: val = 17'd45525;
            7'd45: val = 17'd46341; 7'd46: val = 17'd47143; 7'd47: val = 17'd47930;
            7'd48: val = 17'd48703; 7'd49: val = 17'd49461; 7'd50: val = 17'd50203;
            7'd51: val = 17'd50931; 7'd52: val = 17'd51643; 7'd53: val = 17'd52339;
            7'd54: val = 17'd53020; 7'd55: val = 17'd53684; 7'd56: val = 17'd54332;
            7'd57: val = 17'd54963; 7'd58: val = 17'd55578; 7'd59: val = 17'd56175;
            7'd60: val = 17'd56756; 7'd61: val = 17'd57319; 7'd62: val = 17'd57865;
            7'd63: val = 17'd58393; 7'd64: val = 17'd58903; 7'd65: val = 17'd59396;
            7'd66: val = 17'd59870; 7'd67: val = 17'd60326; 7'd68: val = 17'd60764;
            7'd69: val = 17'd61183; 7'd70: val = 17'd61584; 7'd71: val = 17'd61966;
            7'd72: val = 17'd62328; 7'd73: val = 17'd62672; 7'd74: val = 17'd62997;
            7'd75: val = 17'd63303; 7'd76: val = 17'd63589; 7'd77: val = 17'd63856;
            7'd78: val = 17'd64104; 7'd79: val = 17'd64332; 7'd80: val = 17'd64540;
            7'd81: val = 17'd64729; 7'd82: val = 17'd64898; 7'd83: val = 17'd65048;
            7'd84: val = 17'd65177; 7'd85: val = 17'd65287; 7'd86: val = 17'd65376;
            7'd87: val = 17'd65446; 7'd88: val = 17'd65496; 7'd89: val = 17'd65526;
            7'd90: val = 17'd65536;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/arc_segment_quad_vertices.sv @@
// ----------------------------------------------------------------------------
// arc_segment_quad_vertices: corners of an annular-sector quad
// Four corners (inner/outer radius at start/end angle) from a center point,
// two radii and two angles, each rounded half up and saturated to 0..255.
// Throughput: one item per cycle unless m_tready back-pressure stalls it;
// four register stages (input, angle reduction, sine/cosine, coordinate)
// each with its own valid bit.
// Reset: asynchronous, clears the stage valid bits only; no other state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc_segment_quad_vertices #(
    parameter int ANGLE_FRAC_BITS = asqv_pkg::ANGLE_FRAC_BITS,
    parameter int TRIG_FRAC_BITS  = asqv_pkg::TRIG_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // center_x, center_y, inner_radius, outer_radius, start_angle, end_angle, pad
    input  logic [63:0] s_tdata,
    // result item stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // inner_start_x/y, outer_start_x/y, outer_end_x/y, inner_end_x/y
    output logic [63:0] m_tdata,
    // clipped
    output logic        m_tuser
);

    localparam int CW    = asqv_pkg::COORD_W;
    localparam int AW    = asqv_pkg::ANGLE_W;
    localparam int TBW   = asqv_pkg::TABLE_W;
    localparam int AF    = ANGLE_FRAC_BITS;
    localparam int TF    = TRIG_FRAC_BITS;
    localparam int Q90   = 90 << AF;
    localparam int FULL  = 360 << AF;
    localparam int AMASK = (1 << AF) - 1;
    localparam int AMIN  = 1 << (AW - 1);
    // whole turns added so that every angle becomes non-negative
    localparam int KTURN = (AMIN + FULL - 1) / FULL;
    localparam int XW    = $clog2(AMIN + KTURN * FULL);
    localparam int NW    = XW - 6;
    localparam int RS    = XW;
    localparam int RM    = (1 << RS) / 90;
    localparam int RMW   = $clog2(RM + 1);
    localparam int OW    = $clog2(Q90 + 1);
    localparam int PW    = TBW + OW;
    localparam int HALF_A = (1 << AF) >> 1;
    localparam int HALF_T = (1 << (16 - TF)) >> 1;
    localparam int MW    = TF + 1;
    localparam int TW    = TF + 2;
    localparam int SW    = TF + 11;
    localparam int HALF_C = (1 << TF) >> 1;

    typedef struct packed {
        logic [CW-1:0] center_x;
        logic [CW-1:0] center_y;
        logic [CW-1:0] inner_radius;
        logic [CW-1:0] outer_radius;
    } geom_t;

    typedef struct packed {
        logic [1:0]    quad;
        logic [OW-1:0] off;
    } split_t;

    typedef struct packed {
        logic          neg;
        logic [OW-1:0] off;
    } phase_t;

    typedef struct packed {
        logic [CW-1:0] val;
        logic          clip;
    } coord_t;

    // quadrant and offset within it, by multiply with the reciprocal of 90
    function automatic split_t split_angle(input logic signed [AW-1:0] a);
        logic [XW-1:0]     x;
        logic [XW-1:0]     y;
        logic [XW+RMW-1:0] prod;
        logic [NW-1:0]     n0;
        logic [NW-1:0]     n;
        logic [XW-1:0]     rem;
        logic [XW-1:0]     w;
        split_t            res;
        x    = XW'(int'(a) + KTURN * FULL);
        y    = x >> AF;
        prod = (XW+RMW)'(y) * (XW+RMW)'(RM);
        n0   = NW'(prod >> RS);
        rem  = y - XW'(int'(n0) * 90);
        if (rem >= XW'(90))
        begin
            n = n0 + 1'b1;
            w = rem - XW'(90);
        end
        else
        begin
            n = n0;
            w = rem;
        end
        res.quad = n[1:0];
        res.off  = OW'((w << AF) | (x & XW'(AMASK)));
        return res;
    endfunction

    // mirror odd quadrants, negate the lower half-turn
    function automatic phase_t fold(input logic [1:0] quad, input logic [OW-1:0] off);
        phase_t res;
        res.neg = quad[1];
        res.off = quad[0] ? (OW'(Q90) - off) : off;
        return res;
    endfunction

    // interpolated quarter-wave sine, signed Q1.TF
    function automatic logic signed [TW-1:0] trig_of(input phase_t ph);
        logic [OW-1:0]           deg;
        logic [OW-1:0]           frac;
        logic [TBW-1:0]          t0;
        logic [TBW-1:0]          t1;
        logic [TBW-1:0]          diff;
        logic [PW-1:0]           interp;
        logic [TBW:0]            v;
        logic [MW-1:0]           mag;
        logic signed [TW-1:0]    ms;
        deg    = ph.off >> AF;
        frac   = ph.off & OW'(AMASK);
        t0     = asqv_pkg::sine_q16(7'(deg));
        t1     = asqv_pkg::sine_q16(7'(deg) + 7'd1);
        diff   = t1 - t0;
        interp = (PW'(diff) * PW'(frac) + PW'(HALF_A)) >> AF;
        if (deg >= OW'(90))
            v = (TBW+1)'(asqv_pkg::sine_q16(7'd90));
        else
            v = (TBW+1)'(t0) + (TBW+1)'(interp);
        mag = MW'((v + (TBW+1)'(HALF_T)) >> (16 - TF));
        ms  = signed'(TW'(mag));
        return ph.neg ? -ms : ms;
    endfunction

    // center plus radius times trig, rounded half up and saturated
    function automatic coord_t place(input logic [CW-1:0] c, input logic [CW-1:0] r,
                                     input logic signed [TW-1:0] t);
        logic signed [SW-1:0] rs;
        logic signed [SW-1:0] ts;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] q;
        coord_t               res;
        rs = SW'(signed'({1'b0, r}));
        ts = SW'(t);
        s  = (SW'(c) << TF) + rs * ts + SW'(HALF_C);
        q  = s >>> TF;
        if (q < 0)
        begin
            res.val  = '0;
            res.clip = 1'b1;
        end
        else if (q > SW'(255))
        begin
            res.val  = '1;
            res.clip = 1'b1;
        end
        else
        begin
            res.val  = CW'(q);
            res.clip = 1'b0;
        end
        return res;
    endfunction

    // stage valid bits and ready chain
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = !v0_reg || rdy1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                v0_reg <= s_tvalid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // stage 0: input register
    geom_t                 geom0_reg;
    logic signed [AW-1:0]  start_angle_reg;
    logic signed [AW-1:0]  end_angle_reg;

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            geom0_reg.center_x     <= s_tdata[7:0];
            geom0_reg.center_y     <= s_tdata[15:8];
            geom0_reg.inner_radius <= s_tdata[23:16];
            geom0_reg.outer_radius <= s_tdata[31:24];
            start_angle_reg        <= s_tdata[45:32];
            end_angle_reg          <= s_tdata[59:46];
        end
    end

    // stage 1: angle reduction into folded phases (sin/cos of start/end)
    split_t         split_start;
    split_t         split_end;
    phase_t [3:0]   ph_next;
    phase_t [3:0]   ph_reg;
    geom_t          geom1_reg;

    always_comb
    begin
        split_start = split_angle(start_angle_reg);
        split_end   = split_angle(end_angle_reg);
        ph_next[0]  = fold(split_start.quad, split_start.off);
        ph_next[1]  = fold(split_start.quad + 2'd1, split_start.off);
        ph_next[2]  = fold(split_end.quad, split_end.off);
        ph_next[3]  = fold(split_end.quad + 2'd1, split_end.off);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ph_reg    <= ph_next;
            geom1_reg <= geom0_reg;
        end
    end

    // stage 2: table lookup and interpolation
    logic signed [TW-1:0] trig_next [4];
    logic signed [TW-1:0] trig_reg  [4];
    geom_t                geom2_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            trig_next[i] = trig_of(ph_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            trig_reg  <= trig_next;
            geom2_reg <= geom1_reg;
        end
    end

    // stage 3: corner coordinates into the result register
    coord_t        crd [8];
    logic [63:0]   tdata_reg;
    logic          clip_reg;

    always_comb
    begin
        crd[0] = place(geom2_reg.center_x, geom2_reg.inner_radius, trig_reg[1]);
        crd[1] = place(geom2_reg.center_y, geom2_reg.inner_radius, trig_reg[0]);
        crd[2] = place(geom2_reg.center_x, geom2_reg.outer_radius, trig_reg[1]);
        crd[3] = place(geom2_reg.center_y, geom2_reg.outer_radius, trig_reg[0]);
        crd[4] = place(geom2_reg.center_x, geom2_reg.outer_radius, trig_reg[3]);
        crd[5] = place(geom2_reg.center_y, geom2_reg.outer_radius, trig_reg[2]);
        crd[6] = place(geom2_reg.center_x, geom2_reg.inner_radius, trig_reg[3]);
        crd[7] = place(geom2_reg.center_y, geom2_reg.inner_radius, trig_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            tdata_reg <= {crd[7].val, crd[6].val, crd[5].val, crd[4].val,
                          crd[3].val, crd[2].val, crd[1].val, crd[0].val};
            clip_reg  <= crd[0].clip | crd[1].clip | crd[2].clip | crd[3].clip |
                         crd[4].clip | crd[5].clip | crd[6].clip | crd[7].clip;
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = clip_reg;

    // an empty input stage always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v0_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // folded phase never exceeds a quarter turn
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (ph_reg[0].off <= OW'(Q90)) && (ph_reg[1].off <= OW'(Q90)) &&
                   (ph_reg[2].off <= OW'(Q90)) && (ph_reg[3].off <= OW'(Q90)))
        else $error("folded phase beyond quarter turn");

    // sine and cosine stay within plus or minus one
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (trig_reg[0] <= TW'(1 << TF)) && (trig_reg[0] >= -TW'(1 << TF)) &&
                   (trig_reg[1] <= TW'(1 << TF)) && (trig_reg[1] >= -TW'(1 << TF)) &&
                   (trig_reg[2] <= TW'(1 << TF)) && (trig_reg[2] >= -TW'(1 << TF)) &&
                   (trig_reg[3] <= TW'(1 << TF)) && (trig_reg[3] >= -TW'(1 << TF)))
        else $error("trig value out of range");

    // a result only appears when the previous stage held an item
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(v2_reg))
        else $error("result item without a source item");

endmodule
